// ===== rtl/wavp_pkg.sv =====
// shared result type and report kind codes for the wav header and sample parser
`timescale 1ns / 1ps
package wavp_pkg;

  localparam logic [1:0] KIND_SIZE    = 2'd0;
  localparam logic [1:0] KIND_FORMAT  = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] KIND_SAMPLES = 2'd3;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [32:0] file_bytes;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_bytes;
    logic [15:0] bits_per_sample;
    logic [31:0] payload_bytes;
    logic [23:0] left_sample;
    logic [23:0] right_sample;
  } report_t;

endpackage

// ===== rtl/wavp_parser.sv =====
// byte-wise riff/wave parse state and result formation
`timescale 1ns / 1ps
module wavp_parser #(
  parameter int MAX_SAMPLE_BYTES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output wavp_pkg::report_t res
);
  import wavp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_TAG, PH_FMT, PH_DSIZE, PH_SKIP, PH_SAMPLES, PH_OSIZE
  } phase_t;

  localparam logic [7:0]  CH_F = 8'h66;
  localparam logic [7:0]  CH_M = 8'h6d;
  localparam logic [7:0]  CH_T = 8'h74;
  localparam logic [7:0]  CH_D = 8'h64;
  localparam logic [7:0]  CH_A = 8'h61;
  localparam logic [4:0]  WORD_LAST = 5'd3;
  localparam logic [4:0]  FMT_HDR   = 5'd4;
  localparam logic [4:0]  FMT_LAST  = 5'd19;
  localparam logic [31:0] FMT_LEN   = 32'd16;
  localparam logic [32:0] SIZE_ADJ  = 33'd8;
  localparam logic [2:0]  PER_MAX   = 3'(MAX_SAMPLE_BYTES);
  localparam logic [2:0]  PER_RESET = (MAX_SAMPLE_BYTES >= 2) ? 3'd2 : 3'd1;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [23:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  per_r, per_nxt;
  logic [23:0] left_r, left_nxt;
  logic        right_r, right_nxt;
  logic [7:0]  fmt_r [16];

  logic [31:0] lane;
  logic [31:0] word_acc;
  logic [31:0] len_acc;
  logic [4:0]  cnt_inc;
  logic [31:0] len_dec;
  logic [15:0] bits;
  logic [12:0] bits_q;
  logic [3:0]  fmt_k;

  always_comb begin
    lane     = {24'd0, in_byte} << {cnt_r[1:0], 3'b000};
    word_acc = word_r | lane;
    len_acc  = len_r | lane;
    cnt_inc  = cnt_r + 5'd1;
    len_dec  = (len_r != 32'd0) ? len_r - 32'd1 : 32'd0;
    bits     = {in_byte, fmt_r[14]};
    bits_q   = bits[15:3];
    fmt_k    = cnt_r[3:0] - FMT_HDR[3:0];

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    word_nxt  = word_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    per_nxt   = per_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    res_valid = 1'b0;
    res       = '0;

    if (acc) begin
      unique case (phase_r)
        PH_RIFF, PH_WAVE: begin
          cnt_nxt = cnt_inc;
          if (cnt_r == WORD_LAST) begin
            cnt_nxt  = 5'd0;
            word_nxt = 32'd0;
            if (phase_r == PH_RIFF) begin
              phase_nxt = PH_SIZE;
            end else begin
              phase_nxt = PH_TAG;
              tag_nxt   = 24'd0;
            end
          end
        end
        PH_SIZE: begin
          word_nxt = word_acc;
          cnt_nxt  = cnt_inc;
          if (cnt_r == WORD_LAST) begin
            res_valid       = 1'b1;
            res.report_kind = KIND_SIZE;
            res.file_bytes  = {1'b0, word_acc} + SIZE_ADJ;
            cnt_nxt   = 5'd0;
            word_nxt  = 32'd0;
            phase_nxt = PH_WAVE;
          end
        end
        PH_FMT: begin
          if (cnt_r < FMT_HDR) len_nxt = len_acc;
          cnt_nxt = cnt_inc;
          if (cnt_r == FMT_LAST) begin
            res_valid            = 1'b1;
            res.report_kind      = KIND_FORMAT;
            res.format_code      = {fmt_r[1], fmt_r[0]};
            res.channel_count    = {fmt_r[3], fmt_r[2]};
            res.rate_hz          = {fmt_r[7], fmt_r[6], fmt_r[5], fmt_r[4]};
            res.bytes_per_second = {fmt_r[11], fmt_r[10], fmt_r[9], fmt_r[8]};
            res.frame_bytes      = {fmt_r[13], fmt_r[12]};
            res.bits_per_sample  = bits;
            // bytes per sample, saturated to 1..max
            if (bits_q == 13'd0) begin
              per_nxt = 3'd1;
            end else if (bits_q > 13'(PER_MAX)) begin
              per_nxt = PER_MAX;
            end else begin
              per_nxt = bits_q[2:0];
            end
            len_nxt = (len_r < FMT_LEN) ? 32'd0 : len_r - FMT_LEN;
            cnt_nxt = 5'd0;
            if (len_r > FMT_LEN) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_TAG;
              tag_nxt   = 24'd0;
            end
          end
        end
        PH_DSIZE: begin
          word_nxt = word_acc;
          cnt_nxt  = cnt_inc;
          if (cnt_r == WORD_LAST) begin
            res_valid         = 1'b1;
            res.report_kind   = KIND_DATA;
            res.payload_bytes = word_acc;
            cnt_nxt   = 5'd0;
            word_nxt  = 32'd0;
            right_nxt = 1'b0;
            phase_nxt = PH_SAMPLES;
          end
        end
        PH_SKIP: begin
          len_nxt = len_dec;
          if (len_dec == 32'd0) begin
            phase_nxt = PH_TAG;
            cnt_nxt   = 5'd0;
            tag_nxt   = 24'd0;
          end
        end
        PH_OSIZE: begin
          len_nxt = len_acc;
          cnt_nxt = cnt_inc;
          if (cnt_r == WORD_LAST) begin
            cnt_nxt = 5'd0;
            if (len_acc != 32'd0) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_TAG;
              tag_nxt   = 24'd0;
            end
          end
        end
        PH_SAMPLES: begin
          word_nxt = word_acc;
          cnt_nxt  = cnt_inc;
          if (cnt_inc[2:0] == per_r) begin
            if (!right_r) begin
              left_nxt  = word_acc[23:0];
              right_nxt = 1'b1;
            end else begin
              res_valid        = 1'b1;
              res.report_kind  = KIND_SAMPLES;
              res.left_sample  = left_r;
              res.right_sample = word_acc[23:0];
              right_nxt = 1'b0;
            end
            word_nxt = 32'd0;
            cnt_nxt  = 5'd0;
          end
        end
        default: begin
          tag_nxt = tag_r | lane[23:0];
          cnt_nxt = cnt_inc;
          if (cnt_r == WORD_LAST) begin
            cnt_nxt  = 5'd0;
            word_nxt = 32'd0;
            len_nxt  = 32'd0;
            if (tag_r[7:0] == CH_F && tag_r[15:8] == CH_M && tag_r[23:16] == CH_T) begin
              phase_nxt = PH_FMT;
            end else if (tag_r[7:0] == CH_D && tag_r[15:8] == CH_A &&
                         tag_r[23:16] == CH_T && in_byte == CH_A) begin
              phase_nxt = PH_DSIZE;
            end else begin
              phase_nxt = PH_OSIZE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      cnt_r   <= 5'd0;
      word_r  <= 32'd0;
      tag_r   <= 24'd0;
      len_r   <= 32'd0;
      per_r   <= PER_RESET;
      left_r  <= 24'd0;
      right_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      word_r  <= word_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      per_r   <= per_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  // fmt body bytes, each written once before the report uses it
  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_FMT && cnt_r >= FMT_HDR) begin
      fmt_r[fmt_k] <= in_byte;
    end
  end

endmodule

// ===== rtl/wavp_outbuf.sv =====
// output register with one skid entry for the result channel
`timescale 1ns / 1ps
module wavp_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wavp_pkg::report_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output wavp_pkg::report_t out_data,
  output logic              full
);
  import wavp_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  report_t out_r;
  report_t skid_r;
  logic    take;

  assign take      = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign full      = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input side is held off while the skid entry is in use
      if (take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= push;
      if (push) out_r <= push_data;
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_r       <= push_data;
    end
  end

endmodule

// ===== rtl/wav_header_and_sample_parser.sv =====
// a result is registered into the output register, or into its skid entry while a stalled result is held there
// throughput: one byte beat per cycle while in_stall is low; the parse state updates on each accepted byte
// in_stall rises only when the output register and its skid entry both hold results
// reset: synchronous active-low rst_n returns to expecting the riff tag,
// 16-bit sample depth (8-bit when MAX_SAMPLE_BYTES is 1), and drops any pending result
`timescale 1ns / 1ps
module wav_header_and_sample_parser #(
  parameter int MAX_SAMPLE_BYTES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [32:0] out_file_bytes,
  output logic [15:0] out_format_code,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_rate_hz,
  output logic [31:0] out_bytes_per_second,
  output logic [15:0] out_frame_bytes,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_payload_bytes,
  output logic [23:0] out_left_sample,
  output logic [23:0] out_right_sample
);
  import wavp_pkg::*;

  logic    acc;
  logic    res_valid;
  report_t res;
  report_t out_data;
  logic    full;

  assign acc      = in_valid && !full;
  assign in_stall = full;

  wavp_parser #(
    .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_byte  (in_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  wavp_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (full)
  );

  assign out_report_kind      = out_data.report_kind;
  assign out_file_bytes       = out_data.file_bytes;
  assign out_format_code      = out_data.format_code;
  assign out_channel_count    = out_data.channel_count;
  assign out_rate_hz          = out_data.rate_hz;
  assign out_bytes_per_second = out_data.bytes_per_second;
  assign out_frame_bytes      = out_data.frame_bytes;
  assign out_bits_per_sample  = out_data.bits_per_sample;
  assign out_payload_bytes    = out_data.payload_bytes;
  assign out_left_sample      = out_data.left_sample;
  assign out_right_sample     = out_data.right_sample;

endmodule

// ===== rtl/wavp_checker.sv =====
// port-level checks for the wav header and sample parser, bound to the top level
`timescale 1ns / 1ps
module wavp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_report_kind,
  input logic [32:0] out_file_bytes,
  input logic [15:0] out_format_code,
  input logic [31:0] out_payload_bytes
);
  import wavp_pkg::*;

  // a held result beat keeps its kind
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_kind))
    else $error("result beat changed while stalled");

  // stall on the input side only while a result is already waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // once the waiting result drains, the input side opens again
  a_stall_releases: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && out_valid && !out_stall |=> !in_stall)
    else $error("input stall held after result drained");

  // sample beats carry nothing in the header fields
  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == KIND_SAMPLES |->
      out_file_bytes == 33'd0 && out_format_code == 16'd0 && out_payload_bytes == 32'd0)
    else $error("sample beat has stray header fields");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind wav_header_and_sample_parser wavp_checker u_wavp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_report_kind  (out_report_kind),
  .out_file_bytes   (out_file_bytes),
  .out_format_code  (out_format_code),
  .out_payload_bytes(out_payload_bytes)
);
